// ===== hdl/multi_server_fifo_dispatcher_defines.svh =====
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher assertion macros
// concurrent checks clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVER_FIFO_DISPATCHER_DEFINES_SVH
`define MULTI_SERVER_FIFO_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define MSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msfd_pkg.sv =====
// ----------------------------------------------------------------------------
// msfd_pkg
// shared types, sizes and microcode program of the fifo dispatcher
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam int MAX_SERVERS = 10;
  localparam int QUEUE_DEPTH = 256;

  localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SRVC_W = $clog2(MAX_SERVERS + 1);
  localparam int Q_AW   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 32;

  localparam logic CFG_NUM_SERVERS = 1'b0;
  localparam logic [3:0] NUM_SERVERS_RESET = 4'd4;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  typedef struct packed {
    logic [2:0]  arrivals;
    logic [29:0] service_times;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  server;
    logic [15:0] customer;
    logic [15:0] waited;
    logic [2:0]  duration;
    logic [15:0] served_count;
    logic [8:0]  queue_length;
    logic [2:0]  dropped;
    logic [31:0] total_wait;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_DCHK,
    ST_SEL,
    ST_EMIT,
    ST_TICK,
    ST_SUM
  } step_t;

  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_ARRIVE,
    ACT_NONE,
    ACT_SKIP,
    ACT_EMIT,
    ACT_TICK,
    ACT_SUM
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_ARR_DONE,
    COND_SRV_END,
    COND_TAKE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt;
    step_t alt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      ST_IDLE:   w = '{ACT_LOAD,   COND_IN,       ST_ARRIVE, ST_IDLE};
      ST_ARRIVE: w = '{ACT_ARRIVE, COND_ARR_DONE, ST_DCHK,   ST_ARRIVE};
      ST_DCHK:   w = '{ACT_NONE,   COND_SRV_END,  ST_TICK,   ST_SEL};
      ST_SEL:    w = '{ACT_SKIP,   COND_TAKE,     ST_EMIT,   ST_DCHK};
      ST_EMIT:   w = '{ACT_EMIT,   COND_OUT_FREE, ST_DCHK,   ST_EMIT};
      ST_TICK:   w = '{ACT_TICK,   COND_ALWAYS,   ST_SUM,    ST_SUM};
      ST_SUM:    w = '{ACT_SUM,    COND_OUT_FREE, ST_IDLE,   ST_SUM};
      default:   w = '{ACT_NONE,   COND_ALWAYS,   ST_IDLE,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/multi_server_fifo_dispatcher.sv =====
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher
// tick-driven fifo queue feeding a bank of servers, one request per tick
// ----------------------------------------------------------------------------
// Each request is one time tick. A small microcoded sequencer walks the tick
// one step per cycle while the output is not stalled: it takes the request,
// enqueues each arrival into the single-write queue memory, examines each
// server in use in a check step and a select step and dispatches the queue
// head to each idle one while the queue is not empty, closes the server walk,
// then updates the timers and issues the summary. The dispatch and summary
// steps wait while the output is stalled; the next request is taken once the
// summary sits in the output register.
// ----------------------------------------------------------------------------
`include "multi_server_fifo_dispatcher_defines.svh"

module multi_server_fifo_dispatcher
  import msfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  step_t  pc;
  ucode_t uc;

  logic [3:0]        num_servers;
  logic [2:0]        arr_cnt;
  logic [SRVC_W-1:0] srv;
  logic [29:0]       slots;
  logic [2:0]        dropped;
  logic [Q_AW-1:0]   head;
  logic [QC_W-1:0]   count;
  logic [15:0]       next_customer;
  logic [15:0]       tick;
  logic [31:0]       wait_sum;
  logic              busy   [MAX_SERVERS];
  logic [2:0]        remain [MAX_SERVERS];
  logic [15:0]       served [MAX_SERVERS];

  logic [SRVC_W-1:0] limit;
  logic [SRV_W-1:0]  idx;
  logic              out_free;
  logic              cond_true;
  logic              q_full;
  logic [Q_AW:0]     tail_sum;
  logic [Q_AW-1:0]   tail;
  logic [Q_AW-1:0]   head_next;
  logic              ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [2:0]        dur;
  logic [15:0]       served_next;
  logic [32:0]       sum_wide;
  logic [31:0]       wait_sum_next;
  logic [2:0]        remain_next [MAX_SERVERS];
  out_t              rec_emit;
  out_t              rec_sum;

  assign uc       = ucode_rom(pc);
  assign idx      = srv[SRV_W-1:0];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (pc != ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == CFG_NUM_SERVERS) ? {28'd0, num_servers} : 32'd0;

  always_comb begin
    if (int'(num_servers) > MAX_SERVERS) begin
      limit = SRVC_W'(MAX_SERVERS);
    end else begin
      limit = SRVC_W'(num_servers);
    end
  end

  always_comb begin
    case (uc.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN:       cond_true = in_valid;
      COND_ARR_DONE: cond_true = (arr_cnt == 3'd0);
      COND_SRV_END:  cond_true = (srv >= limit);
      COND_TAKE:     cond_true = !busy[idx] && (count != '0);
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  // queue pointers
  assign q_full    = (count == QC_W'(QUEUE_DEPTH));
  assign tail_sum  = (Q_AW+1)'(head) + (Q_AW+1)'(count);
  assign tail      = (tail_sum >= (Q_AW+1)'(QUEUE_DEPTH)) ?
                     Q_AW'(tail_sum - (Q_AW+1)'(QUEUE_DEPTH)) : Q_AW'(tail_sum);
  assign head_next = (head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head + Q_AW'(1);
  assign ram_we    = (uc.act == ACT_ARRIVE) && (arr_cnt != 3'd0) && !q_full;
  assign ram_wdata = {next_customer + 16'd1, tick};

  msfd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(ram_wdata),
    .raddr(head),
    .rdata(ram_rdata)
  );

  // dispatch and summary records
  assign dur         = (slots[2:0] == 3'd0) ? 3'd1 : slots[2:0];
  assign served_next = (served[idx] == 16'hFFFF) ? 16'hFFFF : served[idx] + 16'd1;
  assign sum_wide    = {1'b0, wait_sum} + 33'(count);
  assign wait_sum_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

  always_comb begin
    rec_emit              = '0;
    rec_emit.kind         = KIND_DISPATCH;
    rec_emit.server       = 4'(srv);
    rec_emit.customer     = ram_rdata[31:16];
    rec_emit.waited       = tick - ram_rdata[15:0];
    rec_emit.duration     = dur;
    rec_emit.served_count = served_next;
    rec_sum               = '0;
    rec_sum.kind          = KIND_SUMMARY;
    rec_sum.queue_length  = 9'(count);
    rec_sum.dropped       = dropped;
    rec_sum.total_wait    = wait_sum;
    rec_sum.last          = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      remain_next[i] = (remain[i] != 3'd0) ? remain[i] - 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= ST_IDLE;
      num_servers   <= NUM_SERVERS_RESET;
      arr_cnt       <= '0;
      srv           <= '0;
      dropped       <= '0;
      head          <= '0;
      count         <= '0;
      next_customer <= '0;
      tick          <= '0;
      wait_sum      <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        busy[i]   <= 1'b0;
        remain[i] <= '0;
        served[i] <= '0;
      end
    end else begin
      pc <= cond_true ? uc.tgt : uc.alt;

      if (psel && penable && pwrite && pready && (paddr[2] == CFG_NUM_SERVERS)) begin
        num_servers <= pwdata[3:0];
      end

      if (out_valid && !out_stall &&
          !((uc.act == ACT_EMIT) || (uc.act == ACT_SUM))) begin
        out_valid <= 1'b0;
      end

      case (uc.act)
        ACT_LOAD: begin
          if (in_valid) begin
            arr_cnt <= in_data.arrivals;
            slots   <= in_data.service_times;
            srv     <= '0;
            dropped <= '0;
          end
        end
        ACT_ARRIVE: begin
          if (arr_cnt != 3'd0) begin
            arr_cnt       <= arr_cnt - 3'd1;
            next_customer <= next_customer + 16'd1;
            if (q_full) begin
              dropped <= dropped + 3'd1;
            end else begin
              count <= count + QC_W'(1);
            end
          end
        end
        ACT_SKIP: begin
          if (!cond_true) begin
            srv <= srv + SRVC_W'(1);
          end
        end
        ACT_EMIT: begin
          out_valid <= out_valid && out_stall;
          if (out_free) begin
            out_valid   <= 1'b1;
            out_data    <= rec_emit;
            busy[idx]   <= 1'b1;
            remain[idx] <= dur;
            served[idx] <= served_next;
            slots       <= {3'd0, slots[29:3]};
            head        <= head_next;
            count       <= count - QC_W'(1);
            srv         <= srv + SRVC_W'(1);
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < MAX_SERVERS; i++) begin
            if (busy[i]) begin
              remain[i] <= remain_next[i];
              if (remain_next[i] == 3'd0) begin
                busy[i] <= 1'b0;
              end
            end
          end
          wait_sum <= wait_sum_next;
          tick     <= tick + 16'd1;
        end
        ACT_SUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= rec_sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `MSFD_ASSERT_NOW(a_count_bound, 1'b1, count <= QC_W'(QUEUE_DEPTH), "queue count above depth")

  `MSFD_ASSERT_NEXT(a_sum_last, (pc == ST_SUM) && out_free, out_valid && out_data.last && (pc == ST_IDLE), "summary not issued as last")

  `MSFD_ASSERT_NEXT(a_emit_busy, (pc == ST_EMIT) && out_free, busy[$past(idx)] && !out_data.last, "dispatch left server idle")

  `MSFD_ASSERT_NOW(a_no_write_full, ram_we, !q_full, "enqueue into full queue")

endmodule

// ===== hdl/msfd_ram.sv =====
// ----------------------------------------------------------------------------
// msfd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module msfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for multi_server_fifo_dispatcher
// drives one tick per request through a valid/stall channel, predicts every
// dispatch record and tick summary in a behavioral copy of the queue and the
// server bank, and checks the results in order while both sides idle and
// stall at random; the server count is changed over the apb port between
// phases, from zero up past the largest bank size
// ----------------------------------------------------------------------------
module testbench
  import msfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT        = 400000;
  localparam int SETTLE       = 50;
  localparam int PRESSURE_AT  = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 370;
  localparam int NUM_DIR      = 14;
  localparam int NUM_PHASES   = 9;
  localparam logic [2:0] REG_ADDR = 3'(4 * CFG_NUM_SERVERS);

  localparam int MODE_MIXED = 0;
  localparam int MODE_FLOOD = 1;
  localparam int MODE_LIGHT = 2;

  typedef struct packed {
    bit          wr;
    logic [3:0]  srv;
    logic [2:0]  arr;
    logic [29:0] slots;
    bit          typed;
    logic [8:0]  qlen;
    logic [2:0]  drop;
    logic [31:0] total;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b0, 4'd0,  3'd0, 30'h0000_0000, 1'b1, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd1, 30'h0000_0000, 1'b1, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd7, 30'h3FFF_FFFF, 1'b1, 9'd3,  3'd0, 32'd3},
    '{1'b0, 4'd0,  3'd0, 30'h0000_0000, 1'b1, 9'd3,  3'd0, 32'd6},
    '{1'b1, 4'd0,  3'd7, 30'h0123_4567, 1'b1, 9'd10, 3'd0, 32'd16},
    '{1'b0, 4'd0,  3'd7, 30'h0000_0000, 1'b1, 9'd17, 3'd0, 32'd33},
    '{1'b1, 4'd15, 3'd0, 30'h0924_9249, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd3, 30'h36DB_6DB6, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b1, 4'd1,  3'd5, 30'h2AAA_AAAA, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd2, 30'h1555_5555, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b1, 4'd10, 3'd7, 30'h3FFF_FFFF, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd4, 30'h0000_0007, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b1, 4'd4,  3'd6, 30'h3FFF_FFF8, 1'b0, 9'd0,  3'd0, 32'd0},
    '{1'b0, 4'd0,  3'd0, 30'h0000_0000, 1'b0, 9'd0,  3'd0, 32'd0}
  };

  localparam int PH_SRV  [NUM_PHASES] = '{4, 0, 10, 15, 1, 7, 10, 2, 0};
  localparam int PH_LEN  [NUM_PHASES] = '{70, 45, 70, 60, 50, 40, 50, 40, 35};
  localparam int PH_MODE [NUM_PHASES] = '{MODE_MIXED, MODE_FLOOD, MODE_LIGHT, MODE_MIXED,
                                          MODE_MIXED, MODE_MIXED, MODE_LIGHT, MODE_MIXED,
                                          MODE_FLOOD};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multi_server_fifo_dispatcher u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the dispatcher
  logic [15:0]       q_ids   [QUEUE_DEPTH];
  logic [15:0]       q_times [QUEUE_DEPTH];
  logic [Q_AW-1:0]   q_head;
  logic [QC_W-1:0]   q_cnt;
  logic [15:0]       next_id;
  logic [15:0]       tick_now;
  bit                busy    [MAX_SERVERS];
  logic [2:0]        remain  [MAX_SERVERS];
  logic [15:0]       served  [MAX_SERVERS];
  logic [31:0]       wait_total;
  logic [3:0]        srv_cfg;

  out_t expected_q [$];

  int  req_count = 0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  dispatch_seen = 0;
  int  dropped_seen = 0;
  int  peak_queue = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  out_t want;
  logic calm;

  assign calm = (req_count >= CALM_FROM) && (req_count < CALM_TO);

  task automatic clear_model();
    q_head = '0;
    q_cnt = '0;
    next_id = '0;
    tick_now = '0;
    wait_total = '0;
    srv_cfg = NUM_SERVERS_RESET;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      busy[i] = 1'b0;
      remain[i] = '0;
      served[i] = '0;
    end
  endtask

  // queues the dispatch records of one tick, hands back its summary
  task automatic predict_tick(input in_t r, output out_t sum);
    int limit;
    int k;
    logic [2:0] drops;
    logic [2:0] dur;
    logic [Q_AW-1:0] tail;
    out_t o;
    limit = (srv_cfg > MAX_SERVERS) ? MAX_SERVERS : int'(srv_cfg);
    drops = '0;
    for (int i = 0; i < r.arrivals; i++) begin
      next_id = next_id + 16'd1;
      if (q_cnt < QUEUE_DEPTH) begin
        tail = q_head + q_cnt[Q_AW-1:0];
        q_ids[tail] = next_id;
        q_times[tail] = tick_now;
        q_cnt = q_cnt + 1'b1;
      end else begin
        drops = drops + 3'd1;
      end
    end
    k = 0;
    for (int i = 0; i < limit; i++) begin
      if (busy[i] || q_cnt == 0) continue;
      dur = (3 * k < 30) ? r.service_times[3 * k +: 3] : 3'd0;
      if (dur == 0) dur = 3'd1;
      busy[i] = 1'b1;
      remain[i] = dur;
      if (served[i] != 16'hFFFF) served[i] = served[i] + 16'd1;
      o = '0;
      o.kind = KIND_DISPATCH;
      o.server = 4'(i);
      o.customer = q_ids[q_head];
      o.waited = tick_now - q_times[q_head];
      o.duration = dur;
      o.served_count = served[i];
      expected_q.push_back(o);
      q_head = q_head + 1'b1;
      q_cnt = q_cnt - 1'b1;
      k++;
    end
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (busy[i]) begin
        if (remain[i] > 0) remain[i] = remain[i] - 3'd1;
        if (remain[i] == 0) busy[i] = 1'b0;
      end
    end
    if (wait_total > 32'hFFFF_FFFF - q_cnt) wait_total = 32'hFFFF_FFFF;
    else wait_total = wait_total + q_cnt;
    tick_now = tick_now + 16'd1;
    sum = '0;
    sum.kind = KIND_SUMMARY;
    sum.queue_length = 9'(q_cnt);
    sum.dropped = drops;
    sum.total_wait = wait_total;
    sum.last = 1'b1;
  endtask

  task automatic send_tick(input in_t r, input bit typed, input logic [8:0] ql,
                           input logic [2:0] dr, input logic [31:0] tw);
    out_t sum;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count++;
    predict_tick(r, sum);
    if (typed) begin
      sum.queue_length = ql;
      sum.dropped = dr;
      sum.total_wait = tw;
    end
    expected_q.push_back(sum);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write the server count, then read it back
  task automatic set_servers(input logic [3:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR;
    pwdata <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    srv_cfg = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {28'd0, v}) begin
      fail_count++;
      if (fail_count <= 10)
        $display("readback: expected %0d got %h", v, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic string fmt_result(input out_t o);
    return $sformatf("kind=%0d srv=%0d cust=%0d wait=%0d dur=%0d served=%0d q=%0d drop=%0d tot=%0d last=%0d",
                     o.kind, o.server, o.customer, o.waited, o.duration, o.served_count,
                     o.queue_length, o.dropped, o.total_wait, o.last);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && req_count >= PRESSURE_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", fmt_result(out_data));
      end else begin
        want = expected_q.pop_front();
        if (want.kind === KIND_DISPATCH) dispatch_seen++;
        else begin
          dropped_seen += want.dropped;
          if (want.queue_length > peak_queue) peak_queue = want.queue_length;
        end
        if (out_data.kind !== want.kind || out_data.server !== want.server ||
            out_data.customer !== want.customer || out_data.waited !== want.waited ||
            out_data.duration !== want.duration ||
            out_data.served_count !== want.served_count ||
            out_data.queue_length !== want.queue_length ||
            out_data.dropped !== want.dropped || out_data.total_wait !== want.total_wait ||
            out_data.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at tick request %0d", req_count);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(out_data));
          end
        end
      end
    end
  end

  initial begin
    in_t req;
    dir_row_t row;
    clear_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      row = DIR_TAB[i];
      if (row.wr) begin
        settle();
        set_servers(row.srv);
      end
      req.arrivals = row.arr;
      req.service_times = row.slots;
      send_tick(req, row.typed, row.qlen, row.drop, row.total);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_servers(4'(PH_SRV[p]));
      for (int n = 0; n < PH_LEN[p]; n++) begin
        case (PH_MODE[p])
          MODE_FLOOD: req.arrivals = ($urandom_range(99) < 80) ? 3'd7 : 3'($urandom_range(7));
          MODE_LIGHT: req.arrivals = 3'($urandom_range(2));
          default:    req.arrivals = 3'($urandom_range(7));
        endcase
        req.service_times = ($urandom_range(9) == 0) ? 30'd0 : 30'($urandom());
        send_tick(req, 1'b0, '0, '0, '0);
      end
    end

    settle();
    if (expected_q.size() != 0) fail_count += expected_q.size();
    $display("%0d ticks over %0d server settings: %0d dispatches, %0d arrivals dropped",
             req_count, NUM_PHASES + 5, dispatch_seen, dropped_seen);
    $display("deepest queue %0d, final wait total %0d, %0d failures",
             peak_queue, wait_total, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== multi_server_fifo_dispatcher.f =====
+incdir+hdl
hdl/msfd_pkg.sv
hdl/msfd_ram.sv
hdl/multi_server_fifo_dispatcher.sv
sim/testbench.sv
